/* hw/rtl/fwc_pkg.sv */
// Shared types and constants for the four-way cache tag block.
package fwc_pkg;

   localparam int TAG_W = 30;
   localparam int AGE_W = 8;
   localparam logic [AGE_W-1:0] AGE_MAX = '1;
   localparam logic [3:0] MIN_OFFSET_BITS = 4'd2;

   localparam logic [1:0] CSR_OFFSET_BITS = 2'd0;
   localparam logic [1:0] CSR_INDEX_BITS  = 2'd1;
   localparam logic [1:0] CSR_POLICY      = 2'd2;

   localparam logic POLICY_LRU  = 1'b0;
   localparam logic POLICY_FIFO = 1'b1;

   localparam logic [3:0] OFFSET_BITS_RESET = 4'd4;
   localparam logic [3:0] INDEX_BITS_RESET  = 4'd4;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_UPDATE
   } fwc_state_type;

   typedef struct packed {
      logic clear;    // sweep one set row to invalid / age zero
      logic accept;   // latch address split, read set row
      logic update;   // resolve lookup, write row back, emit result
   } fwc_cmd_type;

   typedef struct packed {
      logic clear_last;
   } fwc_status_type;

endpackage

/* hw/rtl/fwc_ctrl.sv */
// Controller state machine for the cache tag block.
module fwc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  fwc_pkg::fwc_status_type status,
   output fwc_pkg::fwc_cmd_type    cmd
);
   import fwc_pkg::*;

   fwc_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
         end
         S_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> state_ff == S_CLEAR)
      else $error("reset did not start the clearing pass");
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_UPDATE && busy))
      else $error("accepted word not followed by update");

endmodule

/* hw/rtl/fwc_datapath.sv */
// Datapath: config registers, address split, set memories, lookup and replacement.
module fwc_datapath #(
   parameter int WAYS     = 4,
   parameter int MAX_SETS = 256
) (
   input  logic                    clock,
   input  logic                    reset,
   input  fwc_pkg::fwc_cmd_type    cmd,
   output fwc_pkg::fwc_status_type status,
   input  logic [31:0]             req_address,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [3:0]              csr_data,
   output logic                    rsp_valid,
   output logic                    rsp_hit,
   output logic [31:0]             rsp_hit_count
);
   import fwc_pkg::*;

   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W = $clog2(WAYS);
   // largest e with 2^e <= MAX_SETS
   localparam int MIB = ((1 << $clog2(MAX_SETS)) == MAX_SETS) ?
                        $clog2(MAX_SETS) : $clog2(MAX_SETS) - 1;
   localparam logic [3:0] MIB_C = 4'(MIB);
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(MAX_SETS - 1);

   // configuration
   logic [3:0] offset_bits_ff, index_bits_ff;
   logic       policy_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_bits_ff <= OFFSET_BITS_RESET;
         index_bits_ff  <= INDEX_BITS_RESET;
         policy_ff      <= POLICY_LRU;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_OFFSET_BITS: offset_bits_ff <= csr_data;
            CSR_INDEX_BITS:  index_bits_ff  <= csr_data;
            CSR_POLICY:      policy_ff      <= csr_data[0];
            default: ;
         endcase
      end
   end

   // address split
   logic [3:0]       ob, ib;
   logic [31:0]      block, set_full, tag_full;
   logic [SET_W-1:0] set_idx;
   logic [TAG_W-1:0] tag_idx;

   always_comb begin
      ob       = (offset_bits_ff < MIN_OFFSET_BITS) ? MIN_OFFSET_BITS : offset_bits_ff;
      ib       = (index_bits_ff > MIB_C) ? MIB_C : index_bits_ff;
      block    = req_address >> ob;
      set_full = block & ((32'd1 << ib) - 32'd1);
      tag_full = block >> ib;
      set_idx  = set_full[SET_W-1:0];
      tag_idx  = tag_full[TAG_W-1:0];
   end

   // set memories, one row per set
   logic [WAYS-1:0]                 mem_valid [MAX_SETS];
   logic [WAYS-1:0][AGE_W-1:0]      mem_age   [MAX_SETS];
   logic [WAYS-1:0][TAG_W-1:0]      mem_tag   [MAX_SETS];

   logic [SET_W-1:0]                set_ff, clr_addr_ff;
   logic [TAG_W-1:0]                tag_ff;
   logic [WAYS-1:0]                 row_valid_ff, new_valid_in;
   logic [WAYS-1:0][AGE_W-1:0]      row_age_ff, new_age_in;
   logic [WAYS-1:0][TAG_W-1:0]      row_tag_ff, new_tag_in;

   assign status.clear_last = (clr_addr_ff == LAST_SET);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + SET_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         set_ff       <= set_idx;
         tag_ff       <= tag_idx;
         row_valid_ff <= mem_valid[set_idx];
         row_age_ff   <= mem_age[set_idx];
         row_tag_ff   <= mem_tag[set_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         mem_valid[clr_addr_ff] <= '0;
         mem_age[clr_addr_ff]   <= '0;
      end else if (cmd.update) begin
         mem_valid[set_ff] <= new_valid_in;
         mem_age[set_ff]   <= new_age_in;
         mem_tag[set_ff]   <= new_tag_in;
      end
   end

   // lookup and victim choice
   logic [WAYS-1:0]  hit_vec;
   logic             hit_any;
   logic [WAY_W-1:0] hit_way, inv_way, old_way, victim;
   logic [AGE_W-1:0] hit_age;

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = row_valid_ff[w] && (row_tag_ff[w] == tag_ff);
      end
      hit_any = |hit_vec;
   end

   always_comb begin
      hit_way = '0;
      inv_way = '0;
      old_way = '0;
      // lowest-numbered match / invalid way wins
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) hit_way = WAY_W'(w);
         if (!row_valid_ff[w]) inv_way = WAY_W'(w);
      end
      // oldest way, ties go to the lower number
      for (int w = 1; w < WAYS; w++) begin
         if (row_age_ff[w] > row_age_ff[old_way]) old_way = WAY_W'(w);
      end
      victim  = (&row_valid_ff) ? old_way : inv_way;
      hit_age = row_age_ff[hit_way];
   end

   always_comb begin
      new_valid_in = row_valid_ff;
      new_age_in   = row_age_ff;
      new_tag_in   = row_tag_ff;
      for (int k = 0; k < WAYS; k++) begin
         if (hit_any) begin
            if (policy_ff == POLICY_LRU) begin
               if (WAY_W'(k) == hit_way) begin
                  new_age_in[k] = '0;
               end else if (row_valid_ff[k] && (row_age_ff[k] < hit_age)) begin
                  new_age_in[k] = row_age_ff[k] + AGE_W'(1);
               end
            end
         end else begin
            if (WAY_W'(k) == victim) begin
               new_valid_in[k] = 1'b1;
               new_age_in[k]   = '0;
               new_tag_in[k]   = tag_ff;
            end else if (row_valid_ff[k] && (row_age_ff[k] != AGE_MAX)) begin
               new_age_in[k] = row_age_ff[k] + AGE_W'(1);
            end
         end
      end
   end

   // result and hit counter
   logic        rsp_valid_ff, rsp_hit_ff;
   logic [31:0] hits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
      end else begin
         rsp_valid_ff <= cmd.update;
         if (cmd.update) hits_ff <= hits_ff + 32'(hit_any);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) rsp_hit_ff <= hit_any;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_hit_count = hits_ff;

   a_count_on_hit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (hits_ff != $past(hits_ff))) |-> (rsp_valid_ff && rsp_hit_ff))
      else $error("hit count moved without a hit result");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held longer than one cycle");

endmodule

/* hw/rtl/four_way_cache_tag_lru_fifo.sv */
// Top level of the set-associative cache tag block with LRU/FIFO replacement.
//
//   channel  direction  handshake            payload
//   req      in         start && !busy       req_address[31:0]
//   rsp      out        rsp_valid (1 cycle)  rsp_hit, rsp_hit_count[31:0]
//   csr      in         csr_valid && ready   csr_index[1:0], csr_data[3:0]
//
// For each word, the accept edge reads the set row from the single
// ported row memory, the next edge resolves the lookup and writes the row
// back. rsp_valid is high in the cycle after that, while busy is already low,
// so a new address is taken only once the row has been written back.
// After reset a clearing pass sweeps all MAX_SETS rows, one per cycle; busy
// stays high meanwhile, csr writes still go in.
// The receiver cannot stall: each result shows for exactly one cycle.
module four_way_cache_tag_lru_fifo #(
   parameter int WAYS     = 4,
   parameter int MAX_SETS = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_address,
   // response
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [31:0] rsp_hit_count,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [3:0]  csr_data
);
   import fwc_pkg::*;

   fwc_cmd_type    cmd;
   fwc_status_type status;

   // sequencing: clear sweep, idle/accept, update
   fwc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // address split, set rows, replacement and hit counter
   fwc_datapath #(
      .WAYS     (WAYS),
      .MAX_SETS (MAX_SETS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_address   (req_address),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_hit_count (rsp_hit_count)
   );

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for the four-way cache tag block: mirrored state, directed and random words.
module tb;
   import fwc_pkg::*;

   localparam int WAYS           = 4;
   localparam int MAX_SETS       = 256;
   // MAX_SETS is a power of two, so this is the exact index width limit
   localparam int MAX_INDEX_BITS = $clog2(MAX_SETS);
   // slowest legal run is ~1750 words with idle gaps plus the clear sweep;
   // the limit is several times that
   localparam int CYCLE_LIMIT    = 200000;
   // the result follows the update state and the result register; the tail leaves room for it
   localparam int DRAIN_TAIL     = 16;
   localparam int SHOWN_LIMIT    = 10;
   localparam int POOL_SIZE      = 12;
   localparam int RANDOM_PHASES  = 13;
   localparam int PHASE_WORDS    = 120;
   localparam int LAST_WORDS     = 160;
   // index 3 maps to no register; a write there must leave the split alone
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic        hit;
      logic [31:0] hit_count;
   } lookup_result_type;

   // ---------------------------------------------------------------- DUT ports
   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   logic        busy;
   logic [31:0] req_address = '0;
   logic        rsp_valid;
   logic        rsp_hit;
   logic [31:0] rsp_hit_count;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [3:0]  csr_data  = '0;

   four_way_cache_tag_lru_fifo #(
      .WAYS     (WAYS),
      .MAX_SETS (MAX_SETS)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_address   (req_address),
      .rsp_valid     (rsp_valid),
      .rsp_hit       (rsp_hit),
      .rsp_hit_count (rsp_hit_count),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------ mirrored tag state
   // Our own copy of the tag rows, the live split and policy registers and the hit counter.
   logic [TAG_W-1:0] tag_mirror   [MAX_SETS][WAYS];
   logic             valid_mirror [MAX_SETS][WAYS];
   logic [AGE_W-1:0] age_mirror   [MAX_SETS][WAYS];
   logic [31:0]      hits_mirror;
   logic [3:0]       offset_cfg;
   logic [3:0]       index_cfg;
   logic             policy_cfg;

   lookup_result_type expected_lookups [$];

   int cycle_count     = 0;
   int mismatch_count  = 0;
   int words_sent      = 0;
   int results_checked = 0;
   int hits_seen       = 0;
   int csr_writes      = 0;

   // block size below 4 bytes is raised to 4 bytes
   function automatic int eff_offset();
      return (offset_cfg < MIN_OFFSET_BITS) ? int'(MIN_OFFSET_BITS) : int'(offset_cfg);
   endfunction

   // asking for more sets than exist is clamped to the full set count
   function automatic int eff_index();
      return (int'(index_cfg) > MAX_INDEX_BITS) ? MAX_INDEX_BITS : int'(index_cfg);
   endfunction

   // Byte address of block (tag, set) under the current split, offset bits zero.
   function automatic logic [31:0] split_address(input logic [31:0] tag,
                                                 input logic [31:0] set_idx);
      logic [31:0] set_mask;
      set_mask = (32'd1 << eff_index()) - 32'd1;
      return ((tag << eff_index()) | (set_idx & set_mask)) << eff_offset();
   endfunction

   // One lookup against the mirror: updates tags, valid bits, ages and the
   // hit counter, and returns the result word the block should produce.
   function automatic lookup_result_type cache_lookup(input logic [31:0] addr);
      logic [31:0]       blk;
      logic [TAG_W-1:0]  tag;
      logic [AGE_W-1:0]  hit_age;
      int                set_idx;
      int                found;
      int                victim;
      int                w;
      lookup_result_type r;
      blk     = addr >> eff_offset();
      set_idx = int'(blk & ((32'd1 << eff_index()) - 32'd1));
      tag     = TAG_W'(blk >> eff_index());
      found   = -1;
      for (w = 0; w < WAYS; w++)
         if (found < 0 && valid_mirror[set_idx][w] && tag_mirror[set_idx][w] == tag)
            found = w;
      if (found >= 0) begin
         hits_mirror = hits_mirror + 32'd1;
         // FIFO leaves the ages alone on a hit
         if (policy_cfg == POLICY_LRU) begin
            hit_age = age_mirror[set_idx][found];
            for (w = 0; w < WAYS; w++)
               if (w != found && valid_mirror[set_idx][w] && age_mirror[set_idx][w] < hit_age)
                  age_mirror[set_idx][w] = age_mirror[set_idx][w] + 1'b1;
            age_mirror[set_idx][found] = '0;
         end
      end else begin
         // lowest invalid way first, else the oldest (lowest way wins a tie)
         victim = -1;
         for (w = 0; w < WAYS; w++)
            if (victim < 0 && !valid_mirror[set_idx][w])
               victim = w;
         if (victim < 0) begin
            victim = 0;
            for (w = 1; w < WAYS; w++)
               if (age_mirror[set_idx][w] > age_mirror[set_idx][victim])
                  victim = w;
         end
         for (w = 0; w < WAYS; w++)
            if (w != victim && valid_mirror[set_idx][w] && age_mirror[set_idx][w] < AGE_MAX)
               age_mirror[set_idx][w] = age_mirror[set_idx][w] + 1'b1;
         tag_mirror[set_idx][victim]   = tag;
         valid_mirror[set_idx][victim] = 1'b1;
         age_mirror[set_idx][victim]   = '0;
      end
      r.hit       = (found >= 0);
      r.hit_count = hits_mirror;
      return r;
   endfunction

   // --------------------------------------------------------------- sender side
   // Called right after a rising edge. start stays high on return so that
   // back-to-back words need no second assignment in the same step.
   task automatic send_address(input logic [31:0] addr);
      start       <= 1'b1;
      req_address <= addr;
      // busy read here is the value the block saw at this edge
      do @(posedge clock); while (busy);
      expected_lookups.push_back(cache_lookup(addr));
      words_sent++;
   endtask

   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender pauses until every outstanding result is back; each word yields
   // exactly one result, so the block is idle once the queue is empty.
   task automatic wait_for_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_lookups.size() != 0);
   endtask

   // Register write; only issued while the block holds no words.
   task automatic write_csr(input logic [1:0] idx, input logic [3:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_OFFSET_BITS: offset_cfg = data;
         CSR_INDEX_BITS:  index_cfg  = data;
         CSR_POLICY:      policy_cfg = data[0];
         default: ;
      endcase
      csr_writes++;
      // the extra idle wait keeps csr_valid at a single assignment per step
      @(posedge clock);
   endtask

   // ------------------------------------------------------------ result checker
   function automatic void report_mismatch(input string what, input lookup_result_type want,
                                           input lookup_result_type got);
      mismatch_count++;
      if (mismatch_count <= SHOWN_LIMIT)
         $display("tb: mismatch (%s) #%0d: want hit=%0b count=%0d, got hit=%0b count=%0d",
                  what, results_checked, want.hit, want.hit_count, got.hit, got.hit_count);
   endfunction

   // Results cannot be held off: every strobe is taken at the edge ending it.
   always @(posedge clock) begin
      lookup_result_type due;
      lookup_result_type got;
      if (!reset && rsp_valid) begin
         got = {rsp_hit, rsp_hit_count};
         if (expected_lookups.size() == 0) begin
            report_mismatch("unexpected result", '0, got);
         end else begin
            due = expected_lookups.pop_front();
            results_checked++;
            if (rsp_hit)
               hits_seen++;
            if (rsp_hit !== due.hit)
               report_mismatch("hit", due, got);
            if (rsp_hit_count !== due.hit_count)
               report_mismatch("hit_count", due, got);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------- tests
   // Default split (16-byte blocks, 16 sets): miss then hit within one block,
   // at both ends of the address space.
   task automatic test_basic_hits();
      send_address(32'h0000_0000);
      send_address(32'h0000_000F);
      send_address(32'hFFFF_FFFF);
      send_address(32'hFFFF_FFF0);
   endtask

   // Fill one set, touch the oldest way, then overflow: LRU must evict the
   // second-filled way and keep the touched one.
   task automatic test_lru_replacement();
      int t;
      for (t = 1; t <= 4; t++)
         send_address(split_address(t, 1));
      send_address(split_address(1, 1));
      send_address(split_address(5, 1));
      send_address(split_address(1, 1));
      send_address(split_address(2, 1));
   endtask

   // Policy flipped with the set full: ages carry over and hits stop reordering.
   task automatic test_fifo_replacement();
      wait_for_results();
      write_csr(CSR_POLICY, {3'($urandom_range(0, 7)), POLICY_FIFO});
      send_address(split_address(5, 1));
      send_address(split_address(6, 1));
      send_address(split_address(5, 1));
   endtask

   // Split extremes with the stored rows kept across the change: block size
   // below the floor, index past the set count, then largest blocks, one set, then the unused index.
   task automatic test_config_extremes();
      wait_for_results();
      write_csr(CSR_OFFSET_BITS, 4'd0);
      write_csr(CSR_INDEX_BITS, 4'd15);
      send_address(32'hFFFF_FFFF);
      send_address(32'h0000_0003);
      wait_for_results();
      write_csr(CSR_OFFSET_BITS, 4'd15);
      write_csr(CSR_INDEX_BITS, 4'd0);
      send_address(32'h8000_0000);
      send_address(32'hFFFF_7FFF);
      wait_for_results();
      write_csr(CSR_UNUSED, 4'($urandom_range(0, 15)));
      send_address(32'h1234_5678);
   endtask

   // One phase: fresh split and policy, then mostly words from a small pool of
   // blocks crowded into two sets (hits, fills, evictions), the rest noise.
   task automatic run_random_phase(input int words, input bit with_gaps);
      logic [31:0] pool [POOL_SIZE];
      logic [31:0] anchor_set;
      logic [31:0] addr;
      logic [3:0]  value;
      int          k;
      wait_for_results();
      case ($urandom_range(0, 5))
         0:       value = 4'd0;
         1:       value = 4'd15;
         2:       value = 4'd8;
         default: value = 4'($urandom_range(2, 8));
      endcase
      write_csr(CSR_OFFSET_BITS, value);
      case ($urandom_range(0, 5))
         0:       value = 4'd0;
         1:       value = 4'd15;
         2:       value = 4'd8;
         default: value = 4'($urandom_range(1, 6));
      endcase
      write_csr(CSR_INDEX_BITS, value);
      write_csr(CSR_POLICY, 4'($urandom_range(0, 15)));
      anchor_set = $urandom;
      for (k = 0; k < POOL_SIZE; k++)
         pool[k] = split_address($urandom, (k < POOL_SIZE / 2) ? anchor_set : anchor_set ^ 32'd1);
      for (k = 0; k < words; k++) begin
         if (with_gaps && $urandom_range(0, 7) == 0)
            hold_off($urandom_range(1, 18));
         if ($urandom_range(0, 9) < 7)
            addr = pool[$urandom_range(0, POOL_SIZE - 1)]
                   | ($urandom & ((32'd1 << eff_offset()) - 32'd1));
         else
            addr = $urandom;
         send_address(addr);
      end
   endtask

   // Every third phase runs without gaps; the final stretch has none at all.
   task automatic test_random_traffic();
      int p;
      for (p = 0; p < RANDOM_PHASES; p++)
         run_random_phase(PHASE_WORDS, (p % 3) != 2);
      run_random_phase(LAST_WORDS, 1'b0);
   endtask

   // ------------------------------------------------------------------- main
   initial begin
      int s;
      int w;
      for (s = 0; s < MAX_SETS; s++)
         for (w = 0; w < WAYS; w++) begin
            tag_mirror[s][w]   = '0;
            valid_mirror[s][w] = 1'b0;
            age_mirror[s][w]   = '0;
         end
      hits_mirror = '0;
      offset_cfg  = OFFSET_BITS_RESET;
      index_cfg   = INDEX_BITS_RESET;
      policy_cfg  = POLICY_LRU;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      // the clear sweep after reset shows up as busy; send_address waits it out

      test_basic_hits();
      test_lru_replacement();
      test_fifo_replacement();
      test_config_extremes();
      test_random_traffic();

      wait_for_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("tb: %0d words checked, %0d hits, %0d register writes, %0d mismatches",
               results_checked, hits_seen, csr_writes, mismatch_count);
      $display("tb: covered eviction order, split extremes and %0d random phases",
               RANDOM_PHASES + 1);
      if (mismatch_count == 0 && expected_lookups.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/fwc_pkg.sv
hw/rtl/fwc_ctrl.sv
hw/rtl/fwc_datapath.sv
hw/rtl/four_way_cache_tag_lru_fifo.sv
tb/sv/tb.sv
